/* rtl/lsfp_pkg.sv */
package lsfp_pkg;

    // Item codes carried in the op field.
    typedef enum logic [1:0] {
        OP_CHECK  = 2'd0,
        OP_HW_OVP = 2'd1,
        OP_CLEAR  = 2'd2
    } op_t;

    // Configuration port geometry.
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 30;

    // Register indexes on the configuration port.
    localparam logic [CFG_INDEX_W-1:0] REG_OVP_LIMIT   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_OCP_LIMIT   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SHORT_LIMIT = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_OPP_LIMIT   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_OTP_LIMIT   = 3'd4;

    // Threshold values after reset.
    localparam logic [15:0]        OVP_LIMIT_RST   = 16'd28500;
    localparam logic [13:0]        OCP_LIMIT_RST   = 14'd3200;
    localparam logic [13:0]        SHORT_LIMIT_RST = 14'd5000;
    localparam logic [29:0]        OPP_LIMIT_RST   = 30'd88000000;
    localparam logic signed [11:0] OTP_LIMIT_RST   = 12'sd800;

    // Fault mask layout.
    localparam int MASK_W    = 6;
    localparam int BIT_OVP   = 0;
    localparam int BIT_OCP   = 1;
    localparam int BIT_OPP   = 2;
    localparam int BIT_OTP   = 3;
    localparam int BIT_SHORT = 4;
    localparam int BIT_HWOVP = 5;

    typedef struct packed {
        logic [15:0]        ovp_limit_mv;
        logic [13:0]        ocp_limit_ma;
        logic [13:0]        short_limit_ma;
        logic [29:0]        opp_limit_uw;
        logic signed [11:0] otp_limit_decic;
    } cfg_t;

    typedef struct packed {
        logic [1:0]         op;
        logic [15:0]        vout_mv;
        logic [13:0]        iout_ma;
        logic [15:0]        vin_mv;
        logic signed [11:0] temp_decic;
        logic [31:0]        now_ms;
    } sample_t;

    typedef struct packed {
        logic [MASK_W-1:0]  fault_mask;
        logic               latched_off;
        logic               drive_off;
        logic               has_fault;
        logic [31:0]        fault_time_ms;
        logic [MASK_W-1:0]  snap_mask;
        logic [15:0]        snap_vout_mv;
        logic [13:0]        snap_iout_ma;
        logic [15:0]        snap_vin_mv;
        logic signed [11:0] snap_temp_decic;
    } result_t;

endpackage

/* rtl/lsfp_if.sv */
// Request channel carrying one measured sample or command.
interface lsfp_sample_if;
    logic               valid;
    logic               ready;
    logic [1:0]         op;
    logic [15:0]        vout_mv;
    logic [13:0]        iout_ma;
    logic [15:0]        vin_mv;
    logic signed [11:0] temp_decic;
    logic [31:0]        now_ms;

    modport source (
        output valid, op, vout_mv, iout_ma, vin_mv, temp_decic, now_ms,
        input  ready
    );
    modport sink (
        input  valid, op, vout_mv, iout_ma, vin_mv, temp_decic, now_ms,
        output ready
    );
endinterface

// Result channel carrying the verdict and the recorded state.
interface lsfp_result_if;
    logic               valid;
    logic               ready;
    logic [5:0]         fault_mask;
    logic               latched_off;
    logic               drive_off;
    logic               has_fault;
    logic [31:0]        fault_time_ms;
    logic [5:0]         snap_mask;
    logic [15:0]        snap_vout_mv;
    logic [13:0]        snap_iout_ma;
    logic [15:0]        snap_vin_mv;
    logic signed [11:0] snap_temp_decic;

    modport source (
        output valid, fault_mask, latched_off, drive_off, has_fault, fault_time_ms,
               snap_mask, snap_vout_mv, snap_iout_ma, snap_vin_mv, snap_temp_decic,
        input  ready
    );
    modport sink (
        input  valid, fault_mask, latched_off, drive_off, has_fault, fault_time_ms,
               snap_mask, snap_vout_mv, snap_iout_ma, snap_vin_mv, snap_temp_decic,
        output ready
    );
endinterface

/* rtl/lsfp_cfg.sv */
module lsfp_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [lsfp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [lsfp_pkg::CFG_DATA_W-1:0]  cfg_data,
    output lsfp_pkg::cfg_t                   cfg
);

    lsfp_pkg::cfg_t cfg_reg;
    lsfp_pkg::cfg_t cfg_next;

    // Decode the write into the addressed threshold; unknown indexes are dropped.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                lsfp_pkg::REG_OVP_LIMIT:   cfg_next.ovp_limit_mv    = cfg_data[15:0];
                lsfp_pkg::REG_OCP_LIMIT:   cfg_next.ocp_limit_ma    = cfg_data[13:0];
                lsfp_pkg::REG_SHORT_LIMIT: cfg_next.short_limit_ma  = cfg_data[13:0];
                lsfp_pkg::REG_OPP_LIMIT:   cfg_next.opp_limit_uw    = cfg_data[29:0];
                lsfp_pkg::REG_OTP_LIMIT:   cfg_next.otp_limit_decic = $signed(cfg_data[11:0]);
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ovp_limit_mv    <= lsfp_pkg::OVP_LIMIT_RST;
            cfg_reg.ocp_limit_ma    <= lsfp_pkg::OCP_LIMIT_RST;
            cfg_reg.short_limit_ma  <= lsfp_pkg::SHORT_LIMIT_RST;
            cfg_reg.opp_limit_uw    <= lsfp_pkg::OPP_LIMIT_RST;
            cfg_reg.otp_limit_decic <= lsfp_pkg::OTP_LIMIT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* rtl/lsfp_judge.sv */
module lsfp_judge (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  lsfp_pkg::sample_t smp,
    input  lsfp_pkg::cfg_t    cfg,
    output lsfp_pkg::result_t res
);

    logic [lsfp_pkg::MASK_W-1:0] active_mask_reg, active_mask_next;
    logic                        latch_flag_reg, latch_flag_next;
    logic [31:0]                 fault_stamp_reg, fault_stamp_next;
    logic [lsfp_pkg::MASK_W-1:0] snap_mask_reg, snap_mask_next;
    logic [15:0]                 snap_vout_reg, snap_vout_next;
    logic [13:0]                 snap_iout_reg, snap_iout_next;
    logic [15:0]                 snap_vin_reg, snap_vin_next;
    logic signed [11:0]          snap_temp_reg, snap_temp_next;

    logic [29:0]                 power_uw;
    logic [lsfp_pkg::MASK_W-1:0] check_mask;
    logic [lsfp_pkg::MASK_W-1:0] mask;
    logic                        drive;

    // Threshold comparisons for a check; power is 16x14 and fits in 30 bits.
    always_comb
    begin
        power_uw   = {14'd0, smp.vout_mv} * {16'd0, smp.iout_ma};
        check_mask = '0;
        check_mask[lsfp_pkg::BIT_OVP]   = smp.vout_mv > cfg.ovp_limit_mv;
        check_mask[lsfp_pkg::BIT_OCP]   = smp.iout_ma > cfg.ocp_limit_ma;
        check_mask[lsfp_pkg::BIT_SHORT] = smp.iout_ma > cfg.short_limit_ma;
        check_mask[lsfp_pkg::BIT_OPP]   = power_uw > cfg.opp_limit_uw;
        check_mask[lsfp_pkg::BIT_OTP]   =
            $signed(smp.temp_decic) > $signed(cfg.otp_limit_decic);
    end

    // Next state and reported mask for the item in the input register.
    always_comb
    begin
        active_mask_next = active_mask_reg;
        latch_flag_next  = latch_flag_reg;
        fault_stamp_next = fault_stamp_reg;
        snap_mask_next   = snap_mask_reg;
        snap_vout_next   = snap_vout_reg;
        snap_iout_next   = snap_iout_reg;
        snap_vin_next    = snap_vin_reg;
        snap_temp_next   = snap_temp_reg;
        mask             = active_mask_reg;
        drive            = 1'b0;
        case (smp.op)
            lsfp_pkg::OP_CHECK:
            begin
                // While latched, a check only reports the stored mask.
                if (!latch_flag_reg)
                begin
                    mask = check_mask;
                    if (check_mask != '0)
                    begin
                        drive            = 1'b1;
                        latch_flag_next  = 1'b1;
                        active_mask_next = check_mask;
                        fault_stamp_next = smp.now_ms;
                        snap_mask_next   = check_mask;
                        snap_vout_next   = smp.vout_mv;
                        snap_iout_next   = smp.iout_ma;
                        snap_vin_next    = smp.vin_mv;
                        snap_temp_next   = smp.temp_decic;
                    end
                end
            end
            lsfp_pkg::OP_HW_OVP:
            begin
                drive                                    = 1'b1;
                active_mask_next                         = '0;
                active_mask_next[lsfp_pkg::BIT_HWOVP]    = 1'b1;
                latch_flag_next                          = 1'b1;
                fault_stamp_next                         = smp.now_ms;
                mask                                     = active_mask_next;
            end
            lsfp_pkg::OP_CLEAR:
            begin
                active_mask_next = '0;
                latch_flag_next  = 1'b0;
                mask             = '0;
            end
            default:
            begin
                mask = active_mask_reg;
            end
        endcase
    end

    // The state moves only when the item is handed to the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_mask_reg <= '0;
            latch_flag_reg  <= 1'b0;
            fault_stamp_reg <= '0;
            snap_mask_reg   <= '0;
            snap_vout_reg   <= '0;
            snap_iout_reg   <= '0;
            snap_vin_reg    <= '0;
            snap_temp_reg   <= '0;
        end
        else if (advance)
        begin
            active_mask_reg <= active_mask_next;
            latch_flag_reg  <= latch_flag_next;
            fault_stamp_reg <= fault_stamp_next;
            snap_mask_reg   <= snap_mask_next;
            snap_vout_reg   <= snap_vout_next;
            snap_iout_reg   <= snap_iout_next;
            snap_vin_reg    <= snap_vin_next;
            snap_temp_reg   <= snap_temp_next;
        end
    end

    // Result reflects the state after this item.
    always_comb
    begin
        res.fault_mask      = mask;
        res.latched_off     = latch_flag_next;
        res.drive_off       = drive;
        res.has_fault       = active_mask_next != '0;
        res.fault_time_ms   = fault_stamp_next;
        res.snap_mask       = snap_mask_next;
        res.snap_vout_mv    = snap_vout_next;
        res.snap_iout_ma    = snap_iout_next;
        res.snap_vin_mv     = snap_vin_next;
        res.snap_temp_decic = snap_temp_next;
    end

endmodule

/* rtl/latched_supply_fault_protector_core.sv */
// Channel   Role     Handshake      Contents
// sample    sink     valid/ready    op, vout_mv, iout_ma, vin_mv, temp_decic, now_ms
// result    source   valid/ready    fault_mask, flags, fault_time_ms, snapshot
// cfg       write    cfg_wr_en      cfg_index selects a threshold, cfg_data holds it
//
// One request is accepted per cycle while the result channel is not stalled.
// Each request is judged in a single pass between the input register and the result
// register, with one 16x14 multiply for output power in that path.
// Reset clears the fault state and snapshot and loads the default thresholds.
// A stalled result holds the result register; the input register keeps taking requests
// as long as its contents can move on in the same cycle.
module latched_supply_fault_protector_core (
    input  logic                             clk,
    input  logic                             rst_n,
    lsfp_sample_if.sink                      sample,
    lsfp_result_if.source                    result,
    input  logic                             cfg_wr_en,
    input  logic [lsfp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [lsfp_pkg::CFG_DATA_W-1:0]  cfg_data
);

    lsfp_pkg::cfg_t    cfg;
    lsfp_pkg::sample_t smp_reg, smp_next;
    lsfp_pkg::result_t res_reg, res_next;
    lsfp_pkg::result_t judged;
    logic              smp_valid_reg, smp_valid_next;
    logic              res_valid_reg, res_valid_next;
    logic              advance;
    logic              accept;

    lsfp_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lsfp_judge u_judge (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .smp     (smp_reg),
        .cfg     (cfg),
        .res     (judged)
    );

    // Handshake: the held request moves on whenever the result register is free.
    assign advance      = smp_valid_reg && (!res_valid_reg || result.ready);
    assign sample.ready = !smp_valid_reg || advance;
    assign accept       = sample.valid && sample.ready;

    always_comb
    begin
        smp_next            = smp_reg;
        smp_valid_next      = smp_valid_reg;
        res_next            = res_reg;
        res_valid_next      = res_valid_reg;
        if (advance)
        begin
            smp_valid_next = 1'b0;
            res_next       = judged;
            res_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            res_valid_next = 1'b0;
        end
        if (accept)
        begin
            smp_valid_next      = 1'b1;
            smp_next.op         = sample.op;
            smp_next.vout_mv    = sample.vout_mv;
            smp_next.iout_ma    = sample.iout_ma;
            smp_next.vin_mv     = sample.vin_mv;
            smp_next.temp_decic = sample.temp_decic;
            smp_next.now_ms     = sample.now_ms;
        end
    end

    // Valid flags reset; payload registers only load.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smp_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            smp_valid_reg <= smp_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        smp_reg <= smp_next;
        res_reg <= res_next;
    end

    // Result channel outputs.
    assign result.valid           = res_valid_reg;
    assign result.fault_mask      = res_reg.fault_mask;
    assign result.latched_off     = res_reg.latched_off;
    assign result.drive_off       = res_reg.drive_off;
    assign result.has_fault       = res_reg.has_fault;
    assign result.fault_time_ms   = res_reg.fault_time_ms;
    assign result.snap_mask       = res_reg.snap_mask;
    assign result.snap_vout_mv    = res_reg.snap_vout_mv;
    assign result.snap_iout_ma    = res_reg.snap_iout_ma;
    assign result.snap_vin_mv     = res_reg.snap_vin_mv;
    assign result.snap_temp_decic = res_reg.snap_temp_decic;

endmodule

/* test/latched_supply_fault_protector_core_test.sv */
`timescale 1ns / 100ps

module latched_supply_fault_protector_core_test;

    import lsfp_pkg::*;

    // The op value that the block leaves unused and must ignore.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam int unsigned CYCLE_LIMIT = 300000;
    localparam int          LONG_HOLD_CYCLES = 300;
    localparam int          PHASE_ITEMS = 192;

    // Stall patterns of the result receiver.
    typedef enum int {
        RX_STEADY,
        RX_COIN,
        RX_SPARSE,
        RX_MOSTLY
    } rx_mode_t;

    // Tracks thresholds and fault state, and holds the verdicts still to come.
    class protector_scoreboard;
        cfg_t              limits;
        logic [MASK_W-1:0] active_mask;
        logic              latched;
        logic [31:0]       stamp;
        logic [MASK_W-1:0] snap_mask;
        logic [15:0]       snap_vout;
        logic [13:0]       snap_iout;
        logic [15:0]       snap_vin;
        logic [11:0]       snap_temp;
        result_t           expected_verdicts[$];
        int unsigned       failures;

        function new();
            limits.ovp_limit_mv    = OVP_LIMIT_RST;
            limits.ocp_limit_ma    = OCP_LIMIT_RST;
            limits.short_limit_ma  = SHORT_LIMIT_RST;
            limits.opp_limit_uw    = OPP_LIMIT_RST;
            limits.otp_limit_decic = OTP_LIMIT_RST;
            active_mask = '0;
            latched     = 1'b0;
            stamp       = '0;
            snap_mask   = '0;
            snap_vout   = '0;
            snap_iout   = '0;
            snap_vin    = '0;
            snap_temp   = '0;
            failures    = 0;
        endfunction

        function void write_limit(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_OVP_LIMIT:   limits.ovp_limit_mv    = data[15:0];
                REG_OCP_LIMIT:   limits.ocp_limit_ma    = data[13:0];
                REG_SHORT_LIMIT: limits.short_limit_ma  = data[13:0];
                REG_OPP_LIMIT:   limits.opp_limit_uw    = data[29:0];
                REG_OTP_LIMIT:   limits.otp_limit_decic = data[11:0];
                default: ;
            endcase
        endfunction

        // Applies one request to the fault state and forms its verdict.
        function result_t judge_request(sample_t s);
            result_t           r;
            logic [MASK_W-1:0] found;
            logic [31:0]       power;
            logic              drive;

            found = '0;
            drive = 1'b0;
            case (s.op)
                OP_CHECK:
                begin
                    if (latched)
                    begin
                        found = active_mask;
                    end
                    else
                    begin
                        power = 32'(s.vout_mv) * 32'(s.iout_ma);
                        found[BIT_OVP]   = s.vout_mv > limits.ovp_limit_mv;
                        found[BIT_OCP]   = s.iout_ma > limits.ocp_limit_ma;
                        found[BIT_SHORT] = s.iout_ma > limits.short_limit_ma;
                        found[BIT_OPP]   = power > 32'(limits.opp_limit_uw);
                        found[BIT_OTP]   = $signed(s.temp_decic) >
                                           $signed(limits.otp_limit_decic);
                        if (found != '0)
                        begin
                            drive       = 1'b1;
                            latched     = 1'b1;
                            active_mask = found;
                            stamp       = s.now_ms;
                            snap_mask   = found;
                            snap_vout   = s.vout_mv;
                            snap_iout   = s.iout_ma;
                            snap_vin    = s.vin_mv;
                            snap_temp   = s.temp_decic;
                        end
                    end
                end
                OP_HW_OVP:
                begin
                    drive       = 1'b1;
                    active_mask = '0;
                    active_mask[BIT_HWOVP] = 1'b1;
                    latched     = 1'b1;
                    stamp       = s.now_ms;
                    found       = active_mask;
                end
                OP_CLEAR:
                begin
                    active_mask = '0;
                    latched     = 1'b0;
                end
                default:
                begin
                    found = active_mask;
                end
            endcase

            r.fault_mask      = found;
            r.latched_off     = latched;
            r.drive_off       = drive;
            r.has_fault       = active_mask != '0;
            r.fault_time_ms   = stamp;
            r.snap_mask       = snap_mask;
            r.snap_vout_mv    = snap_vout;
            r.snap_iout_ma    = snap_iout;
            r.snap_vin_mv     = snap_vin;
            r.snap_temp_decic = snap_temp;
            return r;
        endfunction

        function void note_request(sample_t s);
            expected_verdicts.push_back(judge_request(s));
        endfunction

        function void compare_field(string name, longint want, longint got);
            if (want != got)
            begin
                $error("%s mismatch: expected %0d, actual %0d", name, want, got);
                failures++;
            end
        endfunction

        function void check_verdict(result_t got);
            result_t want;

            if (expected_verdicts.size() == 0)
            begin
                $error("result arrived with no request outstanding");
                failures++;
                return;
            end
            want = expected_verdicts.pop_front();
            compare_field("fault_mask", want.fault_mask, got.fault_mask);
            compare_field("latched_off", want.latched_off, got.latched_off);
            compare_field("drive_off", want.drive_off, got.drive_off);
            compare_field("has_fault", want.has_fault, got.has_fault);
            compare_field("fault_time_ms", want.fault_time_ms, got.fault_time_ms);
            compare_field("snap_mask", want.snap_mask, got.snap_mask);
            compare_field("snap_vout_mv", want.snap_vout_mv, got.snap_vout_mv);
            compare_field("snap_iout_ma", want.snap_iout_ma, got.snap_iout_ma);
            compare_field("snap_vin_mv", want.snap_vin_mv, got.snap_vin_mv);
            compare_field("snap_temp_decic", longint'($signed(want.snap_temp_decic)),
                          longint'($signed(got.snap_temp_decic)));
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    bit                     hold_request;
    int                     burst_left;

    protector_scoreboard board = new();

    lsfp_sample_if sample_ch ();
    lsfp_result_if result_ch ();

    latched_supply_fault_protector_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (sample_ch),
        .result    (result_ch),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Watchdog on the total run length.
    initial
    begin
        int unsigned cycle_count;

        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAILURE");
        $finish;
    end

    function automatic result_t capture_result();
        result_t r;

        r.fault_mask      = result_ch.fault_mask;
        r.latched_off     = result_ch.latched_off;
        r.drive_off       = result_ch.drive_off;
        r.has_fault       = result_ch.has_fault;
        r.fault_time_ms   = result_ch.fault_time_ms;
        r.snap_mask       = result_ch.snap_mask;
        r.snap_vout_mv    = result_ch.snap_vout_mv;
        r.snap_iout_ma    = result_ch.snap_iout_ma;
        r.snap_vin_mv     = result_ch.snap_vin_mv;
        r.snap_temp_decic = result_ch.snap_temp_decic;
        return r;
    endfunction

    // Result receiver: checks each accepted result and stalls on its own pattern.
    initial
    begin
        rx_mode_t    mode;
        int          mode_left;
        int          hold_left;
        int unsigned tick;
        logic        next_ready;

        result_ch.ready = 1'b0;
        mode      = RX_STEADY;
        mode_left = 0;
        hold_left = 0;
        tick      = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_ch.valid && result_ch.ready)
            begin
                board.check_verdict(capture_result());
            end
            tick++;
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = LONG_HOLD_CYCLES;
            end
            if (mode_left == 0)
            begin
                mode      = rx_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(16, 96);
            end
            else
            begin
                mode_left--;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                next_ready = 1'b0;
            end
            else
            begin
                case (mode)
                    RX_STEADY: next_ready = 1'b1;
                    RX_COIN:   next_ready = 1'($urandom_range(0, 1));
                    RX_SPARSE: next_ready = (tick % 4) == 0;
                    default:   next_ready = $urandom_range(0, 99) < 85;
                endcase
            end
            result_ch.ready <= next_ready;
        end
    end

    function automatic sample_t make_sample(logic [1:0] op, int vout, int iout, int vin,
                                            int temp, logic [31:0] now);
        sample_t s;

        s.op         = op;
        s.vout_mv    = vout[15:0];
        s.iout_ma    = iout[13:0];
        s.vin_mv     = vin[15:0];
        s.temp_decic = temp[11:0];
        s.now_ms     = now;
        return s;
    endfunction

    function automatic int clamp(int v, int lo, int hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Picks a value anywhere, below a threshold, or right at its edge.
    function automatic int near_value(int limit, int top);
        int v;

        case ($urandom_range(0, 9))
            0, 1, 2:    v = $urandom_range(0, top);
            3, 4, 5, 6: v = $urandom_range(0, limit);
            default:    v = limit + int'($urandom_range(0, 4)) - 2;
        endcase
        return clamp(v, 0, top);
    endfunction

    // Random request, biased toward checks around the current thresholds.
    function automatic sample_t random_request();
        int         pick;
        int         v;
        int         i;
        int         t;
        int         otp;
        logic [1:0] op;

        pick = $urandom_range(0, 99);
        if (pick < 66)
            op = OP_CHECK;
        else if (pick < 76)
            op = OP_HW_OVP;
        else if (pick < 96)
            op = OP_CLEAR;
        else
            op = OP_UNUSED;

        v = near_value(board.limits.ovp_limit_mv, 65535);
        if ($urandom_range(0, 1))
            i = near_value(board.limits.ocp_limit_ma, 16383);
        else
            i = near_value(board.limits.short_limit_ma, 16383);
        // Aim the power right at the overpower threshold now and then.
        if ($urandom_range(0, 4) == 0 && v != 0)
        begin
            i = clamp(int'(board.limits.opp_limit_uw / v) + int'($urandom_range(0, 2)) - 1,
                      0, 16383);
        end

        otp = int'($signed(board.limits.otp_limit_decic));
        case ($urandom_range(0, 2))
            0:       t = int'($urandom_range(0, 2400)) - 400;
            1:       t = int'($urandom_range(0, otp + 400)) - 400;
            default: t = clamp(otp + int'($urandom_range(0, 4)) - 2, -400, 2000);
        endcase
        return make_sample(op, v, i, $urandom_range(0, 65535), t, $urandom());
    endfunction

    function automatic cfg_t random_limits();
        cfg_t c;
        int   t;

        c.ovp_limit_mv   = 16'($urandom_range(0, 65535));
        c.ocp_limit_ma   = 14'($urandom_range(0, 16383));
        c.short_limit_ma = 14'($urandom_range(0, 16383));
        c.opp_limit_uw   = 30'($urandom_range(0, 1073676289));
        t = int'($urandom_range(0, 2400)) - 400;
        c.otp_limit_decic = t[11:0];
        return c;
    endfunction

    // Offers one request, waits for it to be taken, then idles per burst pattern.
    task automatic offer_request(sample_t s);
        sample_ch.valid      <= 1'b1;
        sample_ch.op         <= s.op;
        sample_ch.vout_mv    <= s.vout_mv;
        sample_ch.iout_ma    <= s.iout_ma;
        sample_ch.vin_mv     <= s.vin_mv;
        sample_ch.temp_decic <= s.temp_decic;
        sample_ch.now_ms     <= s.now_ms;
        do
            @(posedge clk);
        while (!sample_ch.ready);
        board.note_request(s);
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            sample_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = $urandom_range(0, 30);
        end
    endtask

    // Stops offering and waits until every verdict has come back.
    task automatic drain_results();
        sample_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (board.expected_verdicts.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    // Writes all five thresholds on consecutive cycles.
    task automatic apply_limits(cfg_t c);
        logic [CFG_INDEX_W-1:0] reg_seq [5];
        logic [CFG_DATA_W-1:0]  data;

        reg_seq[0] = REG_OVP_LIMIT;
        reg_seq[1] = REG_OCP_LIMIT;
        reg_seq[2] = REG_SHORT_LIMIT;
        reg_seq[3] = REG_OPP_LIMIT;
        reg_seq[4] = REG_OTP_LIMIT;
        for (int n = 0; n < 5; n++)
        begin
            case (reg_seq[n])
                REG_OVP_LIMIT:   data = CFG_DATA_W'(c.ovp_limit_mv);
                REG_OCP_LIMIT:   data = CFG_DATA_W'(c.ocp_limit_ma);
                REG_SHORT_LIMIT: data = CFG_DATA_W'(c.short_limit_ma);
                REG_OPP_LIMIT:   data = CFG_DATA_W'(c.opp_limit_uw);
                default:         data = {18'd0, c.otp_limit_decic};
            endcase
            cfg_wr_en <= 1'b1;
            cfg_index <= reg_seq[n];
            cfg_data  <= data;
            @(posedge clk);
            board.write_limit(reg_seq[n], data);
        end
        cfg_wr_en <= 1'b0;
    endtask

    // Main sequence: reset, directed cases, then random phases under several settings.
    initial
    begin
        cfg_t phase_limits;

        rst_n                = 1'b0;
        cfg_wr_en            = 1'b0;
        cfg_index            = '0;
        cfg_data             = '0;
        hold_request         = 1'b0;
        burst_left           = 0;
        sample_ch.valid      = 1'b0;
        sample_ch.op         = OP_CHECK;
        sample_ch.vout_mv    = '0;
        sample_ch.iout_ma    = '0;
        sample_ch.vin_mv     = '0;
        sample_ch.temp_decic = '0;
        sample_ch.now_ms     = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed cases under the reset thresholds.
        offer_request(make_sample(OP_CHECK, 12000, 1000, 24000, 250, 100));
        offer_request(make_sample(OP_CHECK, 28500, 1000, 24000, 250, 105));
        // Current, power and temperature exactly at their thresholds: no fault.
        offer_request(make_sample(OP_CHECK, 27500, 3200, 24000, 800, 110));
        offer_request(make_sample(OP_CHECK, 28501, 1000, 24100, 300, 200));
        // Checks and the unused op while latched only report the stored mask.
        offer_request(make_sample(OP_CHECK, 0, 0, 0, -400, 300));
        offer_request(make_sample(OP_UNUSED, 65535, 16383, 65535, 2000, 310));
        offer_request(make_sample(OP_CLEAR, 0, 0, 0, 0, 320));
        offer_request(make_sample(OP_CHECK, 12000, 3201, 24200, 250, 400));
        offer_request(make_sample(OP_CLEAR, 0, 0, 0, 0, 410));
        offer_request(make_sample(OP_CHECK, 12000, 5001, 24300, 250, 500));
        offer_request(make_sample(OP_CLEAR, 0, 0, 0, 0, 510));
        offer_request(make_sample(OP_CHECK, 28000, 3143, 24400, 250, 600));
        offer_request(make_sample(OP_CLEAR, 0, 0, 0, 0, 610));
        offer_request(make_sample(OP_CHECK, 12000, 1000, 24500, 801, 700));
        offer_request(make_sample(OP_CLEAR, 0, 0, 0, 0, 710));
        offer_request(make_sample(OP_CHECK, 0, 0, 0, -400, 800));
        offer_request(make_sample(OP_HW_OVP, 0, 0, 0, 0, 1000));
        offer_request(make_sample(OP_CHECK, 30000, 6000, 1000, 900, 1010));
        offer_request(make_sample(OP_CLEAR, 0, 0, 0, 0, 1020));
        offer_request(make_sample(OP_CHECK, 65535, 16383, 65535, 2000, 32'hFFFF_FFFF));
        // A hardware event while latched replaces the mask with its own bit.
        offer_request(make_sample(OP_HW_OVP, 0, 0, 0, 0, 32'hFFFF_FFFE));
        offer_request(make_sample(OP_CLEAR, 0, 0, 0, 0, 1100));
        offer_request(make_sample(OP_CLEAR, 0, 0, 0, 0, 1110));
        offer_request(make_sample(OP_UNUSED, 0, 0, 0, 0, 1120));
        offer_request(make_sample(OP_CHECK, 0, 0, 0, 0, 0));

        // Random phases, each under its own thresholds.
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0:
                begin
                    phase_limits.ovp_limit_mv    = '0;
                    phase_limits.ocp_limit_ma    = '0;
                    phase_limits.short_limit_ma  = '0;
                    phase_limits.opp_limit_uw    = '0;
                    phase_limits.otp_limit_decic = -12'sd400;
                end
                1:
                begin
                    phase_limits.ovp_limit_mv    = 16'd65535;
                    phase_limits.ocp_limit_ma    = 14'd16383;
                    phase_limits.short_limit_ma  = 14'd16383;
                    phase_limits.opp_limit_uw    = 30'd1073676289;
                    phase_limits.otp_limit_decic = 12'sd2000;
                end
                3:
                begin
                    phase_limits.ovp_limit_mv    = OVP_LIMIT_RST;
                    phase_limits.ocp_limit_ma    = OCP_LIMIT_RST;
                    phase_limits.short_limit_ma  = SHORT_LIMIT_RST;
                    phase_limits.opp_limit_uw    = OPP_LIMIT_RST;
                    phase_limits.otp_limit_decic = OTP_LIMIT_RST;
                end
                default: phase_limits = random_limits();
            endcase
            drain_results();
            apply_limits(phase_limits);
            @(posedge clk);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // Hold the receiver off for a long stretch so the block backs up.
                if (phase == 2 && n == 60)
                    hold_request = 1'b1;
                // Let everything in flight come back before going on.
                if (phase == 4 && n == 100)
                    drain_results();
                offer_request(random_request());
            end
        end

        drain_results();
        repeat (10) @(posedge clk);
        if (board.failures == 0 && board.expected_verdicts.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
